### hdl/stq_pkg.sv
package stq_pkg;

    // Default sizing of the tree
    localparam int unsigned LEAVES_DEF      = 1024;
    localparam int unsigned VALUE_WIDTH_DEF = 32;

    // Field widths of the beats
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned FIRST_W  = 10;
    localparam int unsigned END_W    = 11;
    localparam int unsigned NEWVAL_W = 32;
    localparam int unsigned ANSWER_W = 32;
    localparam int unsigned MODE_W   = 2;

    // Input tdata layout, lowest bit first
    localparam int unsigned FIRST_LSB  = 0;
    localparam int unsigned END_LSB    = FIRST_LSB + FIRST_W;
    localparam int unsigned NEWVAL_LSB = END_LSB + END_W;
    localparam int unsigned S_DATA_W   = ((NEWVAL_LSB + NEWVAL_W + 7) / 8) * 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // Combining modes; the unused code behaves as the sum
    localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SUM = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ULEAF,
        ST_UPD,
        ST_QTEST,
        ST_QLEFT,
        ST_QRIGHT,
        ST_EMIT
    } state_t;

endpackage

### hdl/segment_tree_range_query.sv
// Segment tree over LEAVES leaves (a power of two) combining VALUE_WIDTH-bit
// two's-complement values by minimum, maximum or wrapping sum, as op_mode
// selects. One item is worked at a time by a sequencer around a single
// combining unit and one store with one write and one registered read port.
// A point update writes the leaf, then rebuilds each ancestor in turn,
// fetching the sibling while writing the parent; a range query walks the
// tree level by level, and each level may need two store reads through
// the single read port; a point read fetches its leaf. After reset and
// after every op_mode write the store is cleared to the mode's identity,
// one entry a cycle, over all 2*LEAVES-1 nodes, and s_tready stays low
// meanwhile. A finished answer waits in an output register, so the next
// beat is taken while it is pending.
module segment_tree_range_query #(
    parameter int unsigned LEAVES      = stq_pkg::LEAVES_DEF,
    parameter int unsigned VALUE_WIDTH = stq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [stq_pkg::MODE_W-1:0]    cfg_wdata,  // op_mode
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stq_pkg::S_DATA_W-1:0]  s_tdata,    // index_first, index_end, new_value
    input  logic [stq_pkg::KIND_W-1:0]    s_tuser,    // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [stq_pkg::ANSWER_W-1:0]  m_tdata     // answer
);

    localparam int unsigned ADDR_WIDTH = $clog2(2 * LEAVES);
    localparam int unsigned NODES      = 2 * LEAVES - 1;

    logic [stq_pkg::MODE_W-1:0] op_mode_reg;
    logic                       mem_we, mem_re;
    logic [ADDR_WIDTH-1:0]      mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0]     mem_wdata, mem_rdata;
    stq_pkg::state_t            state;

    // Hold the combining mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= stq_pkg::MODE_MIN;
        end else if (cfg_we) begin
            op_mode_reg <= cfg_wdata;
        end
    end

    stq_ctrl #(
        .LEAVES      (LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .op_mode   (op_mode_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .state     (state)
    );

    stq_store #(
        .DEPTH      (NODES),
        .ADDR_WIDTH (ADDR_WIDTH),
        .DATA_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk      (aclk),
        .we        (mem_we),
        .waddr     (mem_waddr),
        .wdata     (mem_wdata),
        .re        (mem_re),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rdata)
    );

    // A mode write always starts a clearing pass
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("mode write did not block input");

    // One item in flight at a time; the unused kind is dropped at once
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready
         && (s_tuser == stq_pkg::KIND_UPDATE || s_tuser == stq_pkg::KIND_QUERY
             || s_tuser == stq_pkg::KIND_READ)) |=> !s_tready)
        else $error("second item accepted while busy");

    // Queries never modify the store
    a_query_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        (state == stq_pkg::ST_QTEST || state == stq_pkg::ST_QLEFT
         || state == stq_pkg::ST_QRIGHT) |-> !mem_we)
        else $error("store written during a query");

endmodule

### hdl/stq_store.sv
module stq_store #(
    parameter int unsigned DEPTH      = 2 * stq_pkg::LEAVES_DEF - 1,
    parameter int unsigned ADDR_WIDTH = $clog2(2 * stq_pkg::LEAVES_DEF),
    parameter int unsigned DATA_WIDTH = stq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_WIDTH-1:0] waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic                  re,
    input  logic [ADDR_WIDTH-1:0] raddr,
    output logic [DATA_WIDTH-1:0] rdata_reg
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

endmodule

### hdl/stq_comb.sv
module stq_comb #(
    parameter int unsigned VALUE_WIDTH = stq_pkg::VALUE_WIDTH_DEF
) (
    input  logic [stq_pkg::MODE_W-1:0] mode,
    input  logic [VALUE_WIDTH-1:0]     x,
    input  logic [VALUE_WIDTH-1:0]     y,
    output logic [VALUE_WIDTH-1:0]     z
);

    logic x_le_y;

    assign x_le_y = ($signed(x) <= $signed(y));

    // Select minimum, maximum or wrapping sum
    always_comb begin
        case (mode)
            stq_pkg::MODE_MIN: z = x_le_y ? x : y;
            stq_pkg::MODE_MAX: z = (x == y || !x_le_y) ? x : y;
            default:           z = x + y;
        endcase
    end

endmodule

### hdl/stq_ctrl.sv
module stq_ctrl #(
    parameter int unsigned LEAVES      = stq_pkg::LEAVES_DEF,
    parameter int unsigned VALUE_WIDTH = stq_pkg::VALUE_WIDTH_DEF,
    parameter int unsigned ADDR_WIDTH  = $clog2(2 * LEAVES)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [stq_pkg::MODE_W-1:0]      op_mode,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stq_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [stq_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stq_pkg::ANSWER_W-1:0]    m_tdata,
    output logic                            mem_we,
    output logic [ADDR_WIDTH-1:0]           mem_waddr,
    output logic [VALUE_WIDTH-1:0]          mem_wdata,
    output logic                            mem_re,
    output logic [ADDR_WIDTH-1:0]           mem_raddr,
    input  logic [VALUE_WIDTH-1:0]          mem_rdata,
    output stq_pkg::state_t                 state
);

    localparam int unsigned IW    = ADDR_WIDTH - 1;
    localparam int unsigned NODES = 2 * LEAVES - 1;
    localparam int unsigned BW    = (ADDR_WIDTH > stq_pkg::END_W) ? ADDR_WIDTH
                                                                  : stq_pkg::END_W;
    localparam logic [BW-1:0]         LEAVES_B   = BW'(LEAVES);
    localparam logic [ADDR_WIDTH-1:0] LEAF_BASE  = ADDR_WIDTH'(LEAVES - 1);
    localparam logic [ADDR_WIDTH-1:0] LAST_NODE  = ADDR_WIDTH'(NODES - 1);
    localparam logic [ADDR_WIDTH-1:0] ONE_A      = ADDR_WIDTH'(1);

    stq_pkg::state_t state_reg, state_next;

    logic [ADDR_WIDTH-1:0]         clr_reg, clr_next;
    logic [ADDR_WIDTH-1:0]         k_reg, k_next;
    logic [ADDR_WIDTH-1:0]         a_reg, a_next;
    logic [ADDR_WIDTH-1:0]         b_reg, b_next;
    logic [VALUE_WIDTH-1:0]        left_reg, left_next;
    logic [VALUE_WIDTH-1:0]        right_reg, right_next;
    logic [VALUE_WIDTH-1:0]        res_reg, res_next;
    logic                          out_valid_reg, out_valid_next;
    logic [stq_pkg::ANSWER_W-1:0]  out_data_reg, out_data_next;
    logic                          rd_pending_reg, rd_pending_next;

    logic [stq_pkg::FIRST_W-1:0]   in_first;
    logic [stq_pkg::END_W-1:0]     in_end;
    logic [stq_pkg::NEWVAL_W-1:0]  in_value;
    logic [BW-1:0]                 first_b, end_b;
    logic [ADDR_WIDTH-1:0]         first_sat, end_sat;
    logic [ADDR_WIDTH-1:0]         leaf_addr;
    logic [VALUE_WIDTH-1:0]        identity;
    logic [VALUE_WIDTH-1:0]        comb_x, comb_y, comb_z;
    logic [ADDR_WIDTH-1:0]         k_parent;
    logic [ADDR_WIDTH-1:0]         a_step, b_step, b_less;
    logic                          accept, a_lt_b, out_free;

    // Unpack the input beat
    assign in_first = s_tdata[stq_pkg::FIRST_LSB  +: stq_pkg::FIRST_W];
    assign in_end   = s_tdata[stq_pkg::END_LSB    +: stq_pkg::END_W];
    assign in_value = s_tdata[stq_pkg::NEWVAL_LSB +: stq_pkg::NEWVAL_W];

    // Saturate query bounds to the leaf count; wrap leaf indexes
    assign first_b   = BW'(in_first);
    assign end_b     = BW'(in_end);
    assign first_sat = (first_b > LEAVES_B) ? ADDR_WIDTH'(LEAVES) : ADDR_WIDTH'(first_b);
    assign end_sat   = (end_b > LEAVES_B) ? ADDR_WIDTH'(LEAVES) : ADDR_WIDTH'(end_b);
    assign leaf_addr = ADDR_WIDTH'(IW'(in_first)) + LEAF_BASE;

    // Identity of the current mode
    always_comb begin
        case (op_mode)
            stq_pkg::MODE_MIN: identity = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
            stq_pkg::MODE_MAX: identity = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
            default:           identity = '0;
        endcase
    end

    // Tree walking arithmetic
    assign k_parent = (k_reg - ONE_A) >> 1;
    assign b_less   = b_reg - ONE_A;
    assign a_step   = a_reg >> 1;
    assign b_step   = b_less >> 1;
    assign a_lt_b   = (a_reg < b_reg);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Shared combining unit and its operand selection
    always_comb begin
        case (state_reg)
            stq_pkg::ST_UPD,
            stq_pkg::ST_QLEFT:  begin comb_x = left_reg;  comb_y = mem_rdata; end
            stq_pkg::ST_QRIGHT: begin comb_x = mem_rdata; comb_y = right_reg; end
            default:            begin comb_x = left_reg;  comb_y = right_reg; end
        endcase
    end

    stq_comb #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_comb (
        .mode (op_mode),
        .x    (comb_x),
        .y    (comb_y),
        .z    (comb_z)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stq_pkg::ST_CLEAR: begin
                if (clr_reg == LAST_NODE) state_next = stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        stq_pkg::KIND_UPDATE: state_next = stq_pkg::ST_ULEAF;
                        stq_pkg::KIND_QUERY:  state_next = stq_pkg::ST_QTEST;
                        // a point read waits for the store's registered read, then emits
                        stq_pkg::KIND_READ:   state_next = stq_pkg::ST_EMIT;
                        default:              state_next = stq_pkg::ST_IDLE;
                    endcase
                end
            end
            stq_pkg::ST_ULEAF: state_next = stq_pkg::ST_UPD;
            stq_pkg::ST_UPD: begin
                if (k_parent == '0) state_next = stq_pkg::ST_IDLE;
            end
            stq_pkg::ST_QTEST: begin
                if (!a_lt_b)        state_next = stq_pkg::ST_EMIT;
                else if (!a_reg[0]) state_next = stq_pkg::ST_QLEFT;
                else if (!b_reg[0]) state_next = stq_pkg::ST_QRIGHT;
            end
            stq_pkg::ST_QLEFT: begin
                state_next = b_reg[0] ? stq_pkg::ST_QTEST : stq_pkg::ST_QRIGHT;
            end
            stq_pkg::ST_QRIGHT: state_next = stq_pkg::ST_QTEST;
            stq_pkg::ST_EMIT: begin
                if (out_free) state_next = stq_pkg::ST_IDLE;
            end
            default: state_next = stq_pkg::ST_CLEAR;
        endcase
        if (cfg_we) state_next = stq_pkg::ST_CLEAR;
    end

    // Store ports and datapath registers
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = k_reg;
        mem_wdata       = left_reg;
        mem_re          = 1'b0;
        mem_raddr       = a_reg;
        clr_next        = clr_reg;
        k_next          = k_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        rd_pending_next = rd_pending_reg;

        unique case (state_reg)
            stq_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = identity;
                clr_next  = clr_reg + ONE_A;
            end
            stq_pkg::ST_IDLE: begin
                k_next     = leaf_addr;
                a_next     = first_sat + LEAF_BASE;
                b_next     = end_sat + LEAF_BASE;
                right_next = identity;
                left_next  = (s_tuser == stq_pkg::KIND_UPDATE)
                             ? VALUE_WIDTH'($signed(in_value)) : identity;
                // fetch the leaf for a point read
                mem_re          = accept && (s_tuser == stq_pkg::KIND_READ);
                mem_raddr       = leaf_addr;
                rd_pending_next = accept && (s_tuser == stq_pkg::KIND_READ);
            end
            stq_pkg::ST_ULEAF: begin
                // write the leaf and fetch its sibling
                mem_we    = 1'b1;
                mem_waddr = k_reg;
                mem_wdata = left_reg;
                mem_re    = 1'b1;
                mem_raddr = k_reg[0] ? k_reg + ONE_A : k_reg - ONE_A;
            end
            stq_pkg::ST_UPD: begin
                // rebuild the parent, fetch the parent's sibling
                mem_we    = 1'b1;
                mem_waddr = k_parent;
                mem_wdata = comb_z;
                left_next = comb_z;
                k_next    = k_parent;
                mem_re    = (k_parent != '0);
                mem_raddr = k_parent[0] ? k_parent + ONE_A : k_parent - ONE_A;
            end
            stq_pkg::ST_QTEST: begin
                if (!a_lt_b) begin
                    res_next = comb_z;
                end else if (!a_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = a_reg;
                end else if (!b_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = b_less;
                end else begin
                    a_next = a_step;
                    b_next = b_step;
                end
            end
            stq_pkg::ST_QLEFT: begin
                left_next = comb_z;
                if (!b_reg[0]) begin
                    mem_re    = 1'b1;
                    mem_raddr = b_less;
                end else begin
                    a_next = a_step;
                    b_next = b_step;
                end
            end
            stq_pkg::ST_QRIGHT: begin
                right_next = comb_z;
                a_next     = a_step;
                b_next     = b_step;
            end
            stq_pkg::ST_EMIT: begin
                // a point read takes the leaf held on the store's read port
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_pending_reg
                                     ? stq_pkg::ANSWER_W'($signed(mem_rdata))
                                     : stq_pkg::ANSWER_W'($signed(res_reg));
                end
            end
            default: ;
        endcase

        if (cfg_we) clr_next = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= stq_pkg::ST_CLEAR;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = (state_reg == stq_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign state    = state_reg;

endmodule

### tb/tb_segment_tree_range_query.sv
`timescale 1ns / 100ps

module tb_segment_tree_range_query;

    localparam int unsigned LEAVES     = stq_pkg::LEAVES_DEF;
    localparam int unsigned NODES      = 2 * LEAVES - 1;
    localparam int          SETTLE     = 40;     // longest query walk plus margin
    localparam int          HOLD_LEN   = 400;    // receiver back-pressure stretch
    localparam int          STALL_MAX  = 12000;  // covers a full clear pass and the hold
    localparam int          PHASE_ITEMS = 158;

    localparam logic [stq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [stq_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        bit                           is_cfg;
        logic [stq_pkg::KIND_W-1:0]   code;       // kind, or mode on a register row
        logic [stq_pkg::FIRST_W-1:0]  idx_first;
        logic [stq_pkg::END_W-1:0]    idx_end;
        logic [stq_pkg::NEWVAL_W-1:0] val;
        bit                           typed;
        logic [stq_pkg::ANSWER_W-1:0] ans;
    } plan_row_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [stq_pkg::MODE_W-1:0]     cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [stq_pkg::S_DATA_W-1:0]   s_tdata;
    logic [stq_pkg::KIND_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [stq_pkg::ANSWER_W-1:0]   m_tdata;

    // Predictor state
    logic [31:0]                    tree_vals [NODES];
    logic [stq_pkg::MODE_W-1:0]     model_mode;
    logic [stq_pkg::ANSWER_W-1:0]   pending_answers [$];

    bit                             steady;
    bit                             hold_req;
    int                             mismatches;
    int                             answers_seen;
    int                             n_updates, n_queries, n_reads, n_spare, n_modes;
    int                             quiet_cycles = 0;
    logic [stq_pkg::ANSWER_W-1:0]   want;

    // Directed plan: extremes, every kind, every mode, empty and saturated ranges
    plan_row_t directed_plan [28] = '{
        '{0, stq_pkg::KIND_READ,   10'd0,    11'd0,    32'h0000_0000, 1, 32'h7fff_ffff},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd1024, 32'h0000_0000, 1, 32'h7fff_ffff},
        '{0, stq_pkg::KIND_QUERY,  10'd1023, 11'd0,    32'h0000_0000, 1, 32'h7fff_ffff},
        '{0, stq_pkg::KIND_UPDATE, 10'd0,    11'd0,    32'h8000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_UPDATE, 10'd1023, 11'd2047, 32'h7fff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_UPDATE, 10'd512,  11'd0,    32'hffff_fffb, 0, 32'h0},
        '{0, stq_pkg::KIND_READ,   10'd0,    11'd0,    32'h0000_0000, 1, 32'h8000_0000},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd2047, 32'h0000_0000, 1, 32'h8000_0000},
        '{0, stq_pkg::KIND_QUERY,  10'd1,    11'd1024, 32'h0000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd512,  11'd513,  32'h0000_0000, 0, 32'h0},
        '{0, KIND_SPARE,           10'd1023, 11'd2047, 32'hffff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_READ,   10'd1023, 11'd0,    32'h0000_0000, 1, 32'h7fff_ffff},
        '{1, stq_pkg::MODE_MAX,    10'd0,    11'd0,    32'h0000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd1024, 32'h0000_0000, 1, 32'h8000_0000},
        '{0, stq_pkg::KIND_UPDATE, 10'd7,    11'd0,    32'h7fff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd8,    32'h0000_0000, 0, 32'h0},
        '{1, stq_pkg::MODE_SUM,    10'd0,    11'd0,    32'h0000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_UPDATE, 10'd0,    11'd0,    32'h7fff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_UPDATE, 10'd1,    11'd0,    32'h0000_0001, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd2,    32'h0000_0000, 1, 32'h8000_0000},
        '{0, stq_pkg::KIND_QUERY,  10'd5,    11'd5,    32'h0000_0000, 1, 32'h0000_0000},
        '{1, MODE_SPARE,           10'd0,    11'd0,    32'h0000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_READ,   10'd1,    11'd0,    32'h0000_0000, 1, 32'h0000_0000},
        '{0, stq_pkg::KIND_UPDATE, 10'd1,    11'd0,    32'hffff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_UPDATE, 10'd2,    11'd0,    32'hffff_ffff, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd1024, 32'h0000_0000, 0, 32'h0},
        '{1, stq_pkg::MODE_MIN,    10'd0,    11'd0,    32'h0000_0000, 0, 32'h0},
        '{0, stq_pkg::KIND_QUERY,  10'd0,    11'd1024, 32'h0000_0000, 1, 32'h7fff_ffff}
    };

    segment_tree_range_query u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 aclk = ~aclk;

    // Identity of each combining mode
    function automatic logic [31:0] mode_identity(input logic [stq_pkg::MODE_W-1:0] mode);
        case (mode)
            stq_pkg::MODE_MIN: return 32'h7fff_ffff;
            stq_pkg::MODE_MAX: return 32'h8000_0000;
            default:           return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] merge_pair(input logic [31:0] x, input logic [31:0] y);
        case (model_mode)
            stq_pkg::MODE_MIN: return ($signed(x) <= $signed(y)) ? x : y;
            stq_pkg::MODE_MAX: return ($signed(x) >= $signed(y)) ? x : y;
            default:           return x + y;
        endcase
    endfunction

    function automatic void tree_clear(input logic [stq_pkg::MODE_W-1:0] mode);
        model_mode = mode;
        for (int i = 0; i < NODES; i++) begin
            tree_vals[i] = mode_identity(mode);
        end
    endfunction

    // Write a leaf and rebuild its ancestors up to the root
    function automatic void leaf_write(input int leaf, input logic [31:0] v);
        int k;
        k = leaf + LEAVES - 1;
        tree_vals[k] = v;
        while (k > 0) begin
            k = (k - 1) / 2;
            tree_vals[k] = merge_pair(tree_vals[2 * k + 1], tree_vals[2 * k + 2]);
        end
    endfunction

    // Combine [lo, hi) bottom-up with left and right partials
    function automatic logic [31:0] range_combine(input int lo, input int hi);
        logic [31:0] left_acc;
        logic [31:0] right_acc;
        int          a;
        int          b;
        left_acc  = mode_identity(model_mode);
        right_acc = left_acc;
        if (lo > LEAVES) lo = LEAVES;
        if (hi > LEAVES) hi = LEAVES;
        a = lo + LEAVES - 1;
        b = hi + LEAVES - 1;
        while (a < b) begin
            if (a % 2 == 0) left_acc = merge_pair(left_acc, tree_vals[a]);
            if (b % 2 == 0) right_acc = merge_pair(tree_vals[b - 1], right_acc);
            a = a / 2;
            b = (b - 1) / 2;
        end
        return merge_pair(left_acc, right_acc);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected %h, got %h", $time, what, exp_v, got_v);
        end
    endtask

    // Offer one beat, leave tvalid high after acceptance, then predict
    task automatic offer_item(input logic [stq_pkg::KIND_W-1:0] kind,
                              input logic [stq_pkg::FIRST_W-1:0] idx_first,
                              input logic [stq_pkg::END_W-1:0] idx_end,
                              input logic [stq_pkg::NEWVAL_W-1:0] val,
                              input bit typed,
                              input logic [stq_pkg::ANSWER_W-1:0] typed_ans);
        logic [stq_pkg::S_DATA_W-1:0] beat;
        while (!steady && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        beat = '0;
        beat[stq_pkg::FIRST_LSB +: stq_pkg::FIRST_W]   = idx_first;
        beat[stq_pkg::END_LSB +: stq_pkg::END_W]       = idx_end;
        beat[stq_pkg::NEWVAL_LSB +: stq_pkg::NEWVAL_W] = val;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        s_tuser  <= kind;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        case (kind)
            stq_pkg::KIND_UPDATE: begin
                leaf_write(int'(idx_first), val);
                n_updates++;
            end
            stq_pkg::KIND_QUERY: begin
                pending_answers.push_back(typed ? typed_ans
                                          : range_combine(int'(idx_first), int'(idx_end)));
                n_queries++;
            end
            stq_pkg::KIND_READ: begin
                pending_answers.push_back(typed ? typed_ans
                                          : tree_vals[int'(idx_first) + LEAVES - 1]);
                n_reads++;
            end
            default: n_spare++;
        endcase
    endtask

    // Wait until every answer is back, then let a trailing update finish
    task automatic drain;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [stq_pkg::MODE_W-1:0] mode);
        s_tvalid <= 1'b0;
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        tree_clear(mode);
        n_modes++;
    endtask

    // Receiver: random stalls, a steady stretch, and one long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(posedge aclk);
            end else begin
                m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 34);
            end
        end
    end

    // Check each returned answer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                note_mismatch("answer with none pending", 32'hx, m_tdata);
            end else begin
                want = pending_answers.pop_front();
                if (m_tdata !== want) note_mismatch("answer", want, m_tdata);
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no beat accepted for %0d cycles, %0d answers outstanding",
                     $time, quiet_cycles, pending_answers.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [stq_pkg::MODE_W-1:0]   phase_mode [5];
        logic [stq_pkg::KIND_W-1:0]   kind;
        logic [stq_pkg::FIRST_W-1:0]  idx_first;
        logic [stq_pkg::END_W-1:0]    idx_end;
        logic [stq_pkg::NEWVAL_W-1:0] val;
        int                           n_done;
        int                           pick;

        aresetn      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= stq_pkg::MODE_MIN;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= stq_pkg::KIND_UPDATE;
        steady       = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        answers_seen = 0;
        n_updates    = 0;
        n_queries    = 0;
        n_reads      = 0;
        n_spare      = 0;
        n_modes      = 1;
        tree_clear(stq_pkg::MODE_MIN);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed plan
        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_cfg) begin
                write_mode(directed_plan[i].code);
            end else begin
                offer_item(directed_plan[i].code, directed_plan[i].idx_first,
                           directed_plan[i].idx_end, directed_plan[i].val,
                           directed_plan[i].typed, directed_plan[i].ans);
            end
        end

        // Random phases: each mode, then any; hold-off in the second, no idling in the third
        phase_mode[0] = stq_pkg::MODE_MAX;
        phase_mode[1] = stq_pkg::MODE_SUM;
        phase_mode[2] = MODE_SPARE;
        phase_mode[3] = stq_pkg::MODE_MIN;
        phase_mode[4] = 2'($urandom_range(0, 3));
        for (int ph = 0; ph < 5; ph++) begin
            write_mode(phase_mode[ph]);
            steady = (ph == 2);
            n_done = 0;
            while (n_done < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)      kind = stq_pkg::KIND_UPDATE;
                else if (pick < 75) kind = stq_pkg::KIND_QUERY;
                else if (pick < 95) kind = stq_pkg::KIND_READ;
                else                kind = KIND_SPARE;

                // Keep half the indices in two small windows so reads hit written leaves
                case ($urandom_range(0, 3))
                    0:       idx_first = 10'($urandom_range(0, 15));
                    1:       idx_first = 10'($urandom_range(1008, 1023));
                    default: idx_first = 10'($urandom_range(0, 1023));
                endcase
                case ($urandom_range(0, 9))
                    0:       idx_end = 11'($urandom_range(0, 2047));
                    1:       idx_end = 11'($urandom_range(0, idx_first));
                    2, 3:    idx_end = 11'd1024;
                    default: idx_end = 11'(idx_first + $urandom_range(1, 40));
                endcase
                case ($urandom_range(0, 7))
                    0:       val = 32'h7fff_ffff;
                    1:       val = 32'h8000_0000;
                    2:       val = 32'($urandom_range(0, 15)) - 32'd8;
                    default: val = $urandom;
                endcase

                offer_item(kind, idx_first, idx_end, val, 1'b0, '0);
                if (kind != KIND_SPARE) n_done++;
                // start the long hold-off once items are flowing after the clear
                if (ph == 1 && n_done == 20 && kind != KIND_SPARE) hold_req = 1'b1;
            end
        end
        steady = 1'b0;

        s_tvalid <= 1'b0;
        drain();

        $display("covered %0d updates, %0d range queries, %0d point reads, %0d spare beats",
                 n_updates, n_queries, n_reads, n_spare);
        $display("across %0d mode settings; %0d answers checked, %0d mismatches",
                 n_modes, answers_seen, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
